// ===== sv/scc_pkg.sv =====
package scc_pkg;

  // fixed field widths
  localparam int VIDX_W           = 6;
  localparam int VCNT_W           = 7;
  localparam int MAX_VERTICES_DEF = 64;
  localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture an input beat
    logic edge_rd;    // read rows for an edge update
    logic edge_wr;    // write rows for an edge update
    logic scan_init;  // first pass setup
    logic v_inc;      // advance vertex scan
    logic root_v;     // open a walk at the scanned vertex
    logic p2_init;    // second pass setup
    logic fin_rd;     // fetch next finisher, newest first
    logic root_s;     // open a walk at the fetched finisher
    logic pass2;      // walk uses transposed rows
    logic push;       // descend into lowest unvisited neighbor
    logic pop;        // retire the stack top
    logic top_ld;     // reload stack top from stack memory
    logic comp_inc;   // next component number
    logic out_init;   // result scan setup
    logic out_rd;     // fetch one result
    logic clear;      // drop the whole matrix
  } scc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic v_done;
    logic v_vis;
    logic can_push;
    logic depth_one;
    logic i_zero;
    logic s_vis;
    logic out_last;
    logic last;
  } scc_sts_t;

endpackage

// ===== sv/scc_ram.sv =====
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/scc_ctrl.sv =====
module scc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  scc_pkg::scc_sts_t sts_i,
  output scc_pkg::scc_cmd_t cmd_o
);
  import scc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE_RD, S_EDGE_WR,
    S_P1_INIT, S_P1_SCAN, S_P1_RD, S_P1_EVAL, S_P1_POP,
    S_P2_INIT, S_P2_SCAN, S_P2_CHK, S_P2_RD, S_P2_EVAL, S_P2_POP,
    S_OUT, S_CLEAR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EDGE_RD;
        end
      end
      S_EDGE_RD: begin
        cmd_o.edge_rd = 1'b1;
        state_d       = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        cmd_o.edge_wr = 1'b1;
        state_d       = sts_i.last ? S_P1_INIT : S_IDLE;
      end
      S_P1_INIT: begin
        cmd_o.scan_init = 1'b1;
        state_d         = S_P1_SCAN;
      end
      S_P1_SCAN: begin
        if (sts_i.v_done) begin
          state_d = S_P2_INIT;
        end else begin
          cmd_o.v_inc  = 1'b1;
          cmd_o.root_v = !sts_i.v_vis;
          if (!sts_i.v_vis) state_d = S_P1_RD;
        end
      end
      S_P1_RD: begin
        state_d = S_P1_EVAL;
      end
      S_P1_EVAL: begin
        if (sts_i.can_push) begin
          cmd_o.push = 1'b1;
          state_d    = S_P1_RD;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = sts_i.depth_one ? S_P1_SCAN : S_P1_POP;
        end
      end
      S_P1_POP: begin
        cmd_o.top_ld = 1'b1;
        state_d      = S_P1_RD;
      end
      S_P2_INIT: begin
        cmd_o.p2_init = 1'b1;
        state_d       = S_P2_SCAN;
      end
      S_P2_SCAN: begin
        if (sts_i.i_zero) begin
          cmd_o.out_init = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.fin_rd = 1'b1;
          state_d      = S_P2_CHK;
        end
      end
      S_P2_CHK: begin
        if (sts_i.s_vis) begin
          state_d = S_P2_SCAN;
        end else begin
          cmd_o.root_s = 1'b1;
          state_d      = S_P2_RD;
        end
      end
      S_P2_RD: begin
        cmd_o.pass2 = 1'b1;
        state_d     = S_P2_EVAL;
      end
      S_P2_EVAL: begin
        cmd_o.pass2 = 1'b1;
        if (sts_i.can_push) begin
          cmd_o.push = 1'b1;
          state_d    = S_P2_RD;
        end else begin
          cmd_o.pop = 1'b1;
          if (sts_i.depth_one) begin
            cmd_o.comp_inc = 1'b1;
            state_d        = S_P2_SCAN;
          end else begin
            state_d = S_P2_POP;
          end
        end
      end
      S_P2_POP: begin
        cmd_o.top_ld = 1'b1;
        state_d      = S_P2_RD;
      end
      S_OUT: begin
        cmd_o.out_rd = 1'b1;
        if (sts_i.out_last) state_d = S_CLEAR;
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== sv/scc_dp.sv =====
module scc_dp #(
  parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [scc_pkg::VCNT_W-1:0] cfg_wdata_i,
  input  logic [scc_pkg::VIDX_W-1:0] src_vertex_i,
  input  logic [scc_pkg::VIDX_W-1:0] dst_vertex_i,
  input  logic                       has_edge_i,
  input  logic                       last_i,
  input  scc_pkg::scc_cmd_t          cmd_i,
  output scc_pkg::scc_sts_t          sts_o,
  output logic                       res_valid_o,
  output logic [scc_pkg::VIDX_W-1:0] vertex_o,
  output logic [scc_pkg::VIDX_W-1:0] component_o,
  output logic                       final_res_o
);
  import scc_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = AW + 1;
  localparam int MV = MAX_VERTICES;

  typedef logic [MV-1:0] row_t;

  logic [VCNT_W-1:0] vc_q;
  logic [AW-1:0]     src_q, dst_q;
  logic              edge_q, last_q;
  logic [AW-1:0]     top_q, comp_q;
  logic [CW-1:0]     depth_q, v_q, fin_q, i_q;
  row_t              visited_q, valid_f_q, valid_t_q;
  logic              vf_q, vt_q;
  logic              pend_q, pend_fin_q;
  logic [AW-1:0]     pend_v_q;

  logic [CW-1:0] n_w;
  row_t          mask_w, row_f, row_t_w, cand;
  logic [AW-1:0] u_w;
  logic [AW-1:0] raddr_f, raddr_t, waddr_f, waddr_t;
  row_t          rdata_f, rdata_t, wdata_f, wdata_t;
  logic [AW-1:0] stk_rdata, fin_rdata, comp_rdata, comp_waddr;
  logic          comp_we;

  // vertex count clamped to 1..MAX_VERTICES
  always_comb begin
    if (vc_q == '0) begin
      n_w = CW'(1);
    end else if (vc_q > VCNT_W'(MV)) begin
      n_w = CW'(MV);
    end else begin
      n_w = vc_q[CW-1:0];
    end
    for (int j = 0; j < MV; j++) begin
      mask_w[j] = (CW'(j) < n_w);
    end
  end

  assign row_f   = vf_q ? rdata_f : '0;
  assign row_t_w = vt_q ? rdata_t : '0;
  assign cand    = (cmd_i.pass2 ? row_t_w : row_f) & mask_w & ~visited_q;

  always_comb begin
    u_w = '0;
    for (int j = MV - 1; j >= 0; j--) begin
      if (cand[j]) u_w = AW'(j);
    end
  end

  assign raddr_f = cmd_i.edge_rd ? src_q : top_q;
  assign raddr_t = cmd_i.edge_rd ? dst_q : top_q;
  assign waddr_f = src_q;
  assign waddr_t = dst_q;
  assign wdata_f = row_f | (row_t'(1) << dst_q);
  assign wdata_t = row_t_w | (row_t'(1) << src_q);

  scc_ram #(.WIDTH(MV), .DEPTH(MV)) u_fwd (
    .clk_i, .we_i(cmd_i.edge_wr && edge_q), .waddr_i(waddr_f), .wdata_i(wdata_f),
    .raddr_i(raddr_f), .rdata_o(rdata_f)
  );

  scc_ram #(.WIDTH(MV), .DEPTH(MV)) u_trn (
    .clk_i, .we_i(cmd_i.edge_wr && edge_q), .waddr_i(waddr_t), .wdata_i(wdata_t),
    .raddr_i(raddr_t), .rdata_o(rdata_t)
  );

  scc_ram #(.WIDTH(AW), .DEPTH(MV)) u_stk (
    .clk_i, .we_i(cmd_i.push), .waddr_i(AW'(depth_q - CW'(1))), .wdata_i(top_q),
    .raddr_i(AW'(depth_q - CW'(2))), .rdata_o(stk_rdata)
  );

  scc_ram #(.WIDTH(AW), .DEPTH(MV)) u_fin (
    .clk_i, .we_i(cmd_i.pop && !cmd_i.pass2), .waddr_i(fin_q[AW-1:0]), .wdata_i(top_q),
    .raddr_i(AW'(i_q - CW'(1))), .rdata_o(fin_rdata)
  );

  assign comp_we    = cmd_i.root_s || (cmd_i.push && cmd_i.pass2);
  assign comp_waddr = cmd_i.root_s ? fin_rdata : u_w;

  scc_ram #(.WIDTH(AW), .DEPTH(MV)) u_comp (
    .clk_i, .we_i(comp_we), .waddr_i(comp_waddr), .wdata_i(comp_q),
    .raddr_i(v_q[AW-1:0]), .rdata_o(comp_rdata)
  );

  assign sts_o.v_done    = (v_q >= n_w);
  assign sts_o.v_vis     = visited_q[v_q[AW-1:0]];
  assign sts_o.can_push  = (cand != '0) && (depth_q < CW'(MV));
  assign sts_o.depth_one = (depth_q == CW'(1));
  assign sts_o.i_zero    = (i_q == '0);
  assign sts_o.s_vis     = visited_q[fin_rdata];
  assign sts_o.out_last  = (v_q == n_w - CW'(1));
  assign sts_o.last      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q      <= VCNT_RESET;
      valid_f_q <= '0;
      valid_t_q <= '0;
      pend_q    <= 1'b0;
      depth_q   <= '0;
      v_q       <= '0;
      fin_q     <= '0;
      i_q       <= '0;
      comp_q    <= '0;
      visited_q <= '0;
      edge_q    <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      if (cfg_we_i) vc_q <= cfg_wdata_i;
      pend_q <= cmd_i.out_rd;
      if (cmd_i.latch) begin
        edge_q <= has_edge_i && (VCNT_W'(src_vertex_i) < VCNT_W'(MV))
                             && (VCNT_W'(dst_vertex_i) < VCNT_W'(MV));
        last_q <= last_i;
      end
      if (cmd_i.edge_wr && edge_q) begin
        valid_f_q[src_q] <= 1'b1;
        valid_t_q[dst_q] <= 1'b1;
      end
      if (cmd_i.clear) begin
        valid_f_q <= '0;
        valid_t_q <= '0;
      end
      if (cmd_i.scan_init) begin
        v_q       <= '0;
        fin_q     <= '0;
        visited_q <= '0;
      end
      if (cmd_i.v_inc) v_q <= v_q + CW'(1);
      if (cmd_i.root_v) begin
        depth_q                   <= CW'(1);
        visited_q[v_q[AW-1:0]]    <= 1'b1;
      end
      if (cmd_i.p2_init) begin
        visited_q <= '0;
        i_q       <= fin_q;
        comp_q    <= '0;
      end
      if (cmd_i.fin_rd) i_q <= i_q - CW'(1);
      if (cmd_i.root_s) begin
        depth_q              <= CW'(1);
        visited_q[fin_rdata] <= 1'b1;
      end
      if (cmd_i.push) begin
        depth_q        <= depth_q + CW'(1);
        visited_q[u_w] <= 1'b1;
      end
      if (cmd_i.pop) begin
        depth_q <= depth_q - CW'(1);
        if (!cmd_i.pass2) fin_q <= fin_q + CW'(1);
      end
      if (cmd_i.comp_inc) comp_q <= comp_q + AW'(1);
      if (cmd_i.out_init) v_q <= '0;
      if (cmd_i.out_rd) v_q <= v_q + CW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    vf_q <= valid_f_q[raddr_f];
    vt_q <= valid_t_q[raddr_t];
    if (cmd_i.latch) begin
      src_q <= src_vertex_i[AW-1:0];
      dst_q <= dst_vertex_i[AW-1:0];
    end
    if (cmd_i.root_v) top_q <= v_q[AW-1:0];
    if (cmd_i.root_s) top_q <= fin_rdata;
    if (cmd_i.push)   top_q <= u_w;
    if (cmd_i.top_ld) top_q <= stk_rdata;
    if (cmd_i.out_rd) begin
      pend_v_q   <= v_q[AW-1:0];
      pend_fin_q <= sts_o.out_last;
    end
  end

  assign res_valid_o = pend_q;
  assign vertex_o    = VIDX_W'(pend_v_q);
  assign component_o = VIDX_W'(comp_rdata);
  assign final_res_o = pend_fin_q;

endmodule

// ===== sv/strongly_connected_components.sv =====
// strongly connected components of a directed graph, kosaraju method
//
// input channel: an item is taken when start is high and busy is low.
// each item may carry one edge src_vertex_i -> dst_vertex_i (has_edge_i);
// an item with last_i ends the graph and starts the computation.
// one edge item passes through capture, row read and row write (busy high
// for the last two), a read-modify-write of the adjacency rows.
// a last item then runs two depth-first passes: each push or pop passes
// through a row read and an evaluation, each pop below the root also
// through a stack reload; the walk is limited by the single adjacency
// row port and the stack memory read latency.
// results: n beats, one per cycle, vertex 0..n-1 in order, each marked by
// res_valid_o for one cycle; final_res_o flags the last beat. the
// receiver cannot stall, so results are simply presented once.
// after the last beat the matrix is dropped and busy falls.
// reset: matrix empty, vertex count 64, block idle; no clearing pass.
// configuration: cfg_we_i writes the vertex count; the user must write
// it only while idle, which the block itself does not enforce.
module strongly_connected_components #(
  parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [scc_pkg::VCNT_W-1:0] cfg_wdata_i,
  input  logic                       start,
  output logic                       busy,
  input  logic [scc_pkg::VIDX_W-1:0] src_vertex_i,
  input  logic [scc_pkg::VIDX_W-1:0] dst_vertex_i,
  input  logic                       has_edge_i,
  input  logic                       last_i,
  output logic                       res_valid_o,
  output logic [scc_pkg::VIDX_W-1:0] vertex_o,
  output logic [scc_pkg::VIDX_W-1:0] component_o,
  output logic                       final_res_o
);
  import scc_pkg::*;

  scc_cmd_t cmd;
  scc_sts_t sts;

  // sequencing of load, both walks and the result scan
  scc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .sts_i(sts), .cmd_o(cmd)
  );

  // matrix memories, stack, visited marks and counters
  scc_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .src_vertex_i, .dst_vertex_i, .has_edge_i, .last_i,
    .cmd_i(cmd), .sts_o(sts),
    .res_valid_o, .vertex_o, .component_o, .final_res_o
  );

endmodule

// ===== tb/tb_strongly_connected_components.sv =====
module tb_strongly_connected_components;
  import scc_pkg::*;

  // one result beat
  typedef struct packed {
    logic [VIDX_W-1:0] vertex;
    logic [VIDX_W-1:0] component;
    logic              final_res;
  } vertex_label_t;

  // scoreboard: keeps a copy of the graph and the vertex count, labels the
  // components when a graph closes and checks the result beats in order
  class scc_scoreboard;
    logic [63:0]       graph_rows [64];
    logic [VCNT_W-1:0] n_reg;
    vertex_label_t     labels_due [$];
    int                error_count;

    function void init();
      for (int r = 0; r < 64; r++) graph_rows[r] = '0;
      n_reg = VCNT_RESET;
      labels_due.delete();
      error_count = 0;
    endfunction

    function int lowest_set(logic [63:0] x);
      for (int i = 0; i < 64; i++) if (x[i]) return i;
      return 63;
    endfunction

    function logic [63:0] column_bits(int t, int n);
      logic [63:0] c;
      c = '0;
      for (int u = 0; u < n; u++) if (graph_rows[u][t]) c[u] = 1'b1;
      return c;
    endfunction

    // kosaraju labeling of vertices 0..n-1
    function void label_components();
      int n, fin, comp, depth, t, u, s;
      logic [63:0] mask, seen, cand;
      int order [64];
      int walk [64];
      int comp_of [64];
      vertex_label_t beat;
      n = n_reg;
      if (n < 1) n = 1;
      if (n > 64) n = 64;
      mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      fin = 0;
      comp = 0;
      seen = '0;
      // forward pass, records finishing order
      for (int v = 0; v < n; v++) begin
        if (!seen[v]) begin
          depth = 1;
          walk[0] = v;
          seen[v] = 1'b1;
          while (depth > 0) begin
            t = walk[depth-1];
            cand = graph_rows[t] & mask & ~seen;
            if (cand != 0 && depth < 64) begin
              u = lowest_set(cand);
              seen[u] = 1'b1;
              walk[depth] = u;
              depth++;
            end else begin
              if (fin < 64) begin
                order[fin] = t;
                fin++;
              end
              depth--;
            end
          end
        end
      end
      // transposed pass, newest finisher first
      seen = '0;
      for (int i = fin; i > 0; i--) begin
        s = order[i-1];
        if (!seen[s]) begin
          depth = 1;
          walk[0] = s;
          seen[s] = 1'b1;
          comp_of[s] = comp;
          while (depth > 0) begin
            t = walk[depth-1];
            cand = column_bits(t, n) & mask & ~seen;
            if (cand != 0 && depth < 64) begin
              u = lowest_set(cand);
              seen[u] = 1'b1;
              comp_of[u] = comp;
              walk[depth] = u;
              depth++;
            end else begin
              depth--;
            end
          end
          comp++;
        end
      end
      for (int v = 0; v < n; v++) begin
        beat.vertex = v[VIDX_W-1:0];
        beat.component = comp_of[v][VIDX_W-1:0];
        beat.final_res = (v + 1 == n);
        labels_due.push_back(beat);
      end
      for (int r = 0; r < 64; r++) graph_rows[r] = '0;
    endfunction

    // an accepted input beat
    function void note_edge_beat(logic [VIDX_W-1:0] src, logic [VIDX_W-1:0] dst,
                                 logic has_edge, logic last);
      if (has_edge) graph_rows[src][dst] = 1'b1;
      if (last) label_components();
    endfunction

    task check_label(vertex_label_t got);
      vertex_label_t want;
      if (labels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result v=%0d c=%0d f=%0d",
                                  got.vertex, got.component, got.final_res));
        return;
      end
      want = labels_due.pop_front();
      if (got.vertex !== want.vertex)
        report_mismatch($sformatf("vertex got %0d want %0d", got.vertex, want.vertex));
      if (got.component !== want.component)
        report_mismatch($sformatf("v%0d component got %0d want %0d",
                                  want.vertex, got.component, want.component));
      if (got.final_res !== want.final_res)
        report_mismatch($sformatf("v%0d final got %0d want %0d",
                                  want.vertex, got.final_res, want.final_res));
    endtask

    task report_mismatch(string msg);
      error_count++;
      $display("MISMATCH: %s", msg);
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [VCNT_W-1:0] cfg_wdata_i = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [VIDX_W-1:0] src_vertex_i = '0;
  logic [VIDX_W-1:0] dst_vertex_i = '0;
  logic              has_edge_i = 1'b0;
  logic              last_i = 1'b0;
  logic              res_valid_o;
  logic [VIDX_W-1:0] vertex_o;
  logic [VIDX_W-1:0] component_o;
  logic              final_res_o;

  scc_scoreboard labels = new();
  int  cycle_count = 0;
  bit  allow_gaps = 1'b1;
  localparam int CYCLE_LIMIT = 900000;

  strongly_connected_components dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start, .busy,
    .src_vertex_i, .dst_vertex_i, .has_edge_i, .last_i,
    .res_valid_o, .vertex_o, .component_o, .final_res_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: every strobed beat is taken at the edge ending it
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o)
      labels.check_label('{vertex_o, component_o, final_res_o});
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one edge beat; holds start until taken, and the prediction is noted
  // at the accepting edge. start stays high afterwards: busy covers the
  // next cycles, and a gap or a drain drops it
  task automatic send_edge_beat(int src, int dst, bit has_edge, bit last);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    src_vertex_i <= src[VIDX_W-1:0];
    dst_vertex_i <= dst[VIDX_W-1:0];
    has_edge_i   <= has_edge;
    last_i       <= last;
    do @(posedge clk_i); while (busy);
    labels.note_edge_beat(src[VIDX_W-1:0], dst[VIDX_W-1:0], has_edge, last);
  endtask

  // waits until every label has come, then lets the block settle
  task automatic wait_drained();
    start <= 1'b0;
    while (labels.labels_due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // vertex count may only change while idle
  task automatic write_vertex_count(int value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[VCNT_W-1:0];
    @(posedge clk_i);
    labels.n_reg = value[VCNT_W-1:0];
    cfg_we_i <= 1'b0;
  endtask

  // a random graph: edges mostly within the vertex count, some cycles
  task automatic send_random_graph(int n, int edges);
    int lim, s, d;
    lim = (n < 1) ? 1 : (n > 64 ? 64 : n);
    for (int e = 0; e < edges; e++) begin
      s = $urandom_range(0, lim - 1);
      d = $urandom_range(0, lim - 1);
      if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 63);
      send_edge_beat(s, d, $urandom_range(0, 7) != 0, 1'b0);
    end
    send_edge_beat($urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 1), 1'b1);
  endtask

  initial begin
    int n, edges, sent;
    labels.init();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full 64 vertices, a ring 0..2 joined to 63, extremes of the indices
    send_edge_beat(0, 1, 1, 0);
    send_edge_beat(1, 2, 1, 0);
    send_edge_beat(2, 0, 1, 0);
    send_edge_beat(63, 63, 1, 0);
    send_edge_beat(63, 0, 1, 0);
    send_edge_beat(42, 21, 0, 0);      // no edge carried
    send_edge_beat(2, 63, 1, 1);       // last beat that also adds an edge
    // bare terminator on an empty graph
    send_edge_beat(0, 0, 0, 1);

    // count 0 acts as one vertex
    write_vertex_count(0);
    send_edge_beat(0, 0, 1, 0);
    send_edge_beat(63, 5, 1, 1);
    // count above the maximum acts as 64
    write_vertex_count(127);
    send_edge_beat(10, 11, 1, 0);
    send_edge_beat(11, 10, 1, 1);
    // one vertex, edges beyond the count stored but unseen
    write_vertex_count(1);
    send_edge_beat(0, 3, 1, 0);
    send_edge_beat(3, 0, 1, 1);
    // two vertices, mutual edges
    write_vertex_count(2);
    send_edge_beat(0, 1, 1, 0);
    send_edge_beat(1, 0, 1, 1);
    // long chain, deep stack
    write_vertex_count(64);
    for (int i = 0; i < 63; i++) send_edge_beat(i, i + 1, 1, 0);
    send_edge_beat(63, 0, 1, 1);

    // random graphs, mostly small vertex counts
    sent = 0;
    while (sent < 280) begin
      if ($urandom_range(0, 7) == 0) n = $urandom_range(33, 127);
      else n = $urandom_range(0, 16);
      write_vertex_count(n);
      edges = $urandom_range(0, 2 * ((n < 1) ? 1 : (n > 16 ? 16 : n)));
      if (sent > 220) allow_gaps = 1'b0;
      send_random_graph(n, edges);
      sent += edges + 1;
    end

    wait_drained();
    if (labels.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
